// ===== rtl/rtk_pkg.sv =====
`default_nettype none

package rtk_pkg;

    // Depth of each list and the widths that follow from it.
    localparam int unsigned LIST_DEPTH = 8;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned STATUS_W   = 2;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_RECORD      = 2'd0,
        KIND_READ_TOP    = 2'd1,
        KIND_READ_RECENT = 2'd2,
        KIND_NOP         = 2'd3
    } kind_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FINISHED = 2'd1;

    // Ranking key of one result.
    typedef struct packed {
        logic [DATA_W-1:0] score;
        logic [DATA_W-1:0] penalty;
        logic [DATA_W-1:0] seq_num;
    } key_t;

    // One recent list entry.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        key_t                key;
    } rec_entry_t;

    // Control that the top level hands to each top list cell.
    typedef struct packed {
        logic insert;
        logic occupied;
        logic left_go;
    } top_ctl_t;

    // True when key a ranks strictly ahead of key b.
    function automatic logic key_before(input key_t a, input key_t b);
        logic result;
        if (a.score != b.score)
        begin
            result = (a.score < b.score);
        end
        else if (a.penalty != b.penalty)
        begin
            result = (a.penalty < b.penalty);
        end
        else
        begin
            result = (a.seq_num < b.seq_num);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ranked_top_k_result_store.sv =====
`default_nettype none

// Channel  | handshake                   | payload
// ---------+-----------------------------+---------------------------------------------------
// item     | item_valid / item_ready     | kind status score_time penalty_time slot_index
// result   | result_valid / result_ready | ok ranked rank_position counts entry_* (4 fields)
//
// For each item, the compare row of the top list cells and the read muxes settle
// in the cycle of the transfer, and the result is registered.
// One item per cycle is sustained while the result side keeps taking results.
// The result register stalls the item side only while it holds an untaken result.
// Reset clears the counts, the sequence counter (to one) and the result valid.

module ranked_top_k_result_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [1:0]                    kind,
    input  wire logic [rtk_pkg::STATUS_W-1:0]  status,
    input  wire logic [rtk_pkg::DATA_W-1:0]    score_time,
    input  wire logic [rtk_pkg::DATA_W-1:0]    penalty_time,
    input  wire logic [rtk_pkg::IDX_W-1:0]     slot_index,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic                               ok,
    output logic                               ranked,
    output logic [rtk_pkg::IDX_W-1:0]          rank_position,
    output logic [rtk_pkg::CNT_W-1:0]          top_entries,
    output logic [rtk_pkg::CNT_W-1:0]          recent_entries,
    output logic [rtk_pkg::STATUS_W-1:0]       entry_status,
    output logic [rtk_pkg::DATA_W-1:0]         entry_score,
    output logic [rtk_pkg::DATA_W-1:0]         entry_penalty,
    output logic [rtk_pkg::DATA_W-1:0]         entry_sequence
);
    import rtk_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

    // Control state.
    logic [CNT_W-1:0]  top_fill_reg;
    logic [CNT_W-1:0]  top_fill_next;
    logic [CNT_W-1:0]  recent_fill_reg;
    logic [CNT_W-1:0]  recent_fill_next;
    logic [DATA_W-1:0] next_seq_reg;
    logic [DATA_W-1:0] next_seq_next;
    logic              result_valid_reg;
    logic              result_valid_next;

    // Result register.
    logic                ok_reg;
    logic                ok_next;
    logic                ranked_reg;
    logic                ranked_next;
    logic [IDX_W-1:0]    rank_pos_reg;
    logic [IDX_W-1:0]    rank_pos_next;
    logic [STATUS_W-1:0] entry_status_reg;
    logic [STATUS_W-1:0] entry_status_next;
    key_t                entry_key_reg;
    key_t                entry_key_next;

    // Cell row signals.
    logic              item_xfer;
    logic              do_record;
    logic              do_insert;
    key_t              new_key;
    rec_entry_t        new_entry;
    logic [LIST_DEPTH-1:0] go_vec;
    top_ctl_t          top_ctl   [LIST_DEPTH];
    key_t              top_key   [LIST_DEPTH];
    rec_entry_t        rec_entry [LIST_DEPTH];
    logic [IDX_W-1:0]  insert_pos;

    assign item_ready = !result_valid_reg || result_ready;
    assign item_xfer  = item_valid && item_ready;

    assign new_key.score   = score_time;
    assign new_key.penalty = penalty_time;
    assign new_key.seq_num = next_seq_reg;
    assign new_entry.status = status;
    assign new_entry.key    = new_key;

    assign do_record = item_xfer && (kind == KIND_RECORD) && (status != STATUS_NONE);
    assign do_insert = do_record && (status == STATUS_FINISHED) && go_vec[LIST_DEPTH-1];

    // Row of top list cells, kept in ranking order.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_top
        assign top_ctl[i].insert   = do_insert;
        assign top_ctl[i].occupied = (CNT_W'(i) < top_fill_reg);
        if (i == 0)
        begin : g_head
            assign top_ctl[i].left_go = 1'b0;
            rtk_top_cell u_cell (
                .clk      (clk),
                .ctl      (top_ctl[i]),
                .new_key  (new_key),
                .left_key (new_key),
                .go       (go_vec[i]),
                .entry    (top_key[i])
            );
        end
        else
        begin : g_body
            assign top_ctl[i].left_go = go_vec[i-1];
            rtk_top_cell u_cell (
                .clk      (clk),
                .ctl      (top_ctl[i]),
                .new_key  (new_key),
                .left_key (top_key[i-1]),
                .go       (go_vec[i]),
                .entry    (top_key[i])
            );
        end
    end

    // Row of recent list cells, newest at the head.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_recent
        if (i == 0)
        begin : g_head
            rtk_recent_cell u_cell (
                .clk        (clk),
                .push       (do_record),
                .left_entry (new_entry),
                .entry      (rec_entry[i])
            );
        end
        else
        begin : g_body
            rtk_recent_cell u_cell (
                .clk        (clk),
                .push       (do_record),
                .left_entry (rec_entry[i-1]),
                .entry      (rec_entry[i])
            );
        end
    end

    // Insertion point: the lowest cell whose go flag is set.
    always_comb
    begin
        insert_pos = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (go_vec[i])
            begin
                insert_pos = IDX_W'(i);
            end
        end
    end

    // Next values of the counts and the sequence counter.
    always_comb
    begin
        top_fill_next    = top_fill_reg;
        recent_fill_next = recent_fill_reg;
        next_seq_next    = next_seq_reg;
        if (do_record)
        begin
            next_seq_next = next_seq_reg + DATA_W'(1);
            if (recent_fill_reg < DEPTH_CNT)
            begin
                recent_fill_next = recent_fill_reg + CNT_W'(1);
            end
        end
        if (do_insert && (top_fill_reg < DEPTH_CNT))
        begin
            top_fill_next = top_fill_reg + CNT_W'(1);
        end
    end

    // Result contents for the item in transfer.
    always_comb
    begin
        ok_next           = 1'b0;
        ranked_next       = 1'b0;
        rank_pos_next     = '0;
        entry_status_next = '0;
        entry_key_next    = '0;
        unique case (kind)
            KIND_RECORD:
            begin
                if (status != STATUS_NONE)
                begin
                    ok_next           = 1'b1;
                    entry_status_next = status;
                    entry_key_next    = new_key;
                    if (do_insert)
                    begin
                        ranked_next   = 1'b1;
                        rank_pos_next = insert_pos;
                    end
                end
            end
            KIND_READ_TOP:
            begin
                if ({1'b0, slot_index} < top_fill_reg)
                begin
                    ok_next           = 1'b1;
                    entry_status_next = STATUS_FINISHED;
                    entry_key_next    = top_key[slot_index];
                end
            end
            KIND_READ_RECENT:
            begin
                if ({1'b0, slot_index} < recent_fill_reg)
                begin
                    ok_next           = 1'b1;
                    entry_status_next = rec_entry[slot_index].status;
                    entry_key_next    = rec_entry[slot_index].key;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Result valid is set by a transfer in and cleared by a transfer out.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (item_xfer)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_fill_reg     <= '0;
            recent_fill_reg  <= '0;
            next_seq_reg     <= DATA_W'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            top_fill_reg     <= top_fill_next;
            recent_fill_reg  <= recent_fill_next;
            next_seq_reg     <= next_seq_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload loads on each item transfer.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            ok_reg           <= ok_next;
            ranked_reg       <= ranked_next;
            rank_pos_reg     <= rank_pos_next;
            entry_status_reg <= entry_status_next;
            entry_key_reg    <= entry_key_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign ok             = ok_reg;
    assign ranked         = ranked_reg;
    assign rank_position  = rank_pos_reg;
    assign top_entries    = top_fill_reg;
    assign recent_entries = recent_fill_reg;
    assign entry_status   = entry_status_reg;
    assign entry_score    = entry_key_reg.score;
    assign entry_penalty  = entry_key_reg.penalty;
    assign entry_sequence = entry_key_reg.seq_num;

`ifndef SYNTHESIS
    // Neither count ever passes the list depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (top_fill_reg <= DEPTH_CNT) && (recent_fill_reg <= DEPTH_CNT))
        else $error("list count above depth");

    // The top list stays sorted, so the go flags rise once along the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(go_vec & ~(go_vec << 1)))
        else $error("top list go flags not monotone");

    // A stored record consumes exactly one sequence number.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_record |=> (next_seq_reg == $past(next_seq_reg) + DATA_W'(1)))
        else $error("sequence counter did not advance");

    // An insertion into the top list implies an accepted record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && ranked_reg) |-> ok_reg)
        else $error("ranked result without ok");

    // After an insertion into the top list, neither count is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (top_fill_reg != '0) && (recent_fill_reg != '0))
        else $error("insertion left an empty count");
`endif

endmodule

`default_nettype wire

// ===== rtl/rtk_top_cell.sv =====
`default_nettype none

module rtk_top_cell (
    input  wire logic          clk,
    input  wire rtk_pkg::top_ctl_t ctl,
    input  wire rtk_pkg::key_t new_key,
    input  wire rtk_pkg::key_t left_key,
    output logic               go,
    output rtk_pkg::key_t      entry
);
    import rtk_pkg::*;

    key_t entry_reg;
    key_t entry_next;

    // The new key belongs at or ahead of this slot if the slot is empty or
    // holds a key that ranks after it.
    assign go = !ctl.occupied || key_before(new_key, entry_reg);

    // Take the new key at the insertion point, shift from the left beyond it.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert)
        begin
            if (ctl.left_go)
            begin
                entry_next = left_key;
            end
            else if (go)
            begin
                entry_next = new_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/rtk_recent_cell.sv =====
`default_nettype none

module rtk_recent_cell (
    input  wire logic               clk,
    input  wire logic               push,
    input  wire rtk_pkg::rec_entry_t left_entry,
    output rtk_pkg::rec_entry_t     entry
);
    import rtk_pkg::*;

    rec_entry_t entry_reg;
    rec_entry_t entry_next;

    // On a push every cell takes its left neighbor, the oldest falls off.
    always_comb
    begin
        entry_next = push ? left_entry : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== tb/sv/ranked_top_k_result_store_tb.sv =====
`default_nettype none

module ranked_top_k_result_store_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtk_pkg::*;

    // Status codes that the package leaves unnamed.
    localparam logic [STATUS_W-1:0] STATUS_UNFINISHED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SPARE      = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLDOFF_LEN  = 80;
    localparam int unsigned REPORT_LIMIT = 10;

    // One result as it leaves the block.
    typedef struct {
        logic                ok;
        logic                ranked;
        logic [IDX_W-1:0]    rank_position;
        logic [CNT_W-1:0]    top_entries;
        logic [CNT_W-1:0]    recent_entries;
        logic [STATUS_W-1:0] entry_status;
        logic [DATA_W-1:0]   entry_score;
        logic [DATA_W-1:0]   entry_penalty;
        logic [DATA_W-1:0]   entry_sequence;
    } store_reply_t;

    // Mirror of both lists, plus the replies still owed by the block.
    class rank_store_scoreboard;
        rec_entry_t   recent_list[LIST_DEPTH];
        key_t         top_list[LIST_DEPTH];
        int unsigned  recent_fill;
        int unsigned  top_fill;
        logic [31:0]  next_seq;
        store_reply_t replies_due[$];
        int unsigned  mismatches;

        function new();
            recent_fill = 0;
            top_fill    = 0;
            next_seq    = 32'd1;
            mismatches  = 0;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        // Ascending on score, then penalty, then sequence.
        function bit ahead_of(key_t a, key_t b);
            if (a.score != b.score)
            begin
                return a.score < b.score;
            end
            if (a.penalty != b.penalty)
            begin
                return a.penalty < b.penalty;
            end
            return a.seq_num < b.seq_num;
        endfunction

        // Apply one accepted request and queue the reply it must produce.
        function void note_request(kind_t k, logic [STATUS_W-1:0] st, logic [DATA_W-1:0] sc,
                                   logic [DATA_W-1:0] pe, logic [IDX_W-1:0] slot);
            store_reply_t r;
            key_t         entry_key;
            int unsigned  pos;
            r = '{default: '0};
            case (k)
                KIND_RECORD:
                begin
                    if (st != STATUS_NONE)
                    begin
                        entry_key.score   = sc;
                        entry_key.penalty = pe;
                        entry_key.seq_num = next_seq;
                        next_seq          = next_seq + 32'd1;

                        // Newest entry goes to the front; the oldest drops off a full list.
                        for (int i = LIST_DEPTH - 1; i > 0; i--)
                        begin
                            recent_list[i] = recent_list[i-1];
                        end
                        recent_list[0].status = st;
                        recent_list[0].key    = entry_key;
                        if (recent_fill < LIST_DEPTH)
                        begin
                            recent_fill++;
                        end
                        r.ok             = 1'b1;
                        r.entry_status   = st;
                        r.entry_score    = sc;
                        r.entry_penalty  = pe;
                        r.entry_sequence = entry_key.seq_num;

                        // Finished results are also placed in rank order.
                        if (st == STATUS_FINISHED)
                        begin
                            pos = 0;
                            while (pos < top_fill && !ahead_of(entry_key, top_list[pos]))
                            begin
                                pos++;
                            end
                            if (pos < LIST_DEPTH)
                            begin
                                for (int i = LIST_DEPTH - 1; i > int'(pos); i--)
                                begin
                                    top_list[i] = top_list[i-1];
                                end
                                top_list[pos] = entry_key;
                                if (top_fill < LIST_DEPTH)
                                begin
                                    top_fill++;
                                end
                                r.ranked        = 1'b1;
                                r.rank_position = pos[IDX_W-1:0];
                            end
                        end
                    end
                end
                KIND_READ_TOP:
                begin
                    if (slot < top_fill)
                    begin
                        r.ok             = 1'b1;
                        r.entry_status   = STATUS_FINISHED;
                        r.entry_score    = top_list[slot].score;
                        r.entry_penalty  = top_list[slot].penalty;
                        r.entry_sequence = top_list[slot].seq_num;
                    end
                end
                KIND_READ_RECENT:
                begin
                    if (slot < recent_fill)
                    begin
                        r.ok             = 1'b1;
                        r.entry_status   = recent_list[slot].status;
                        r.entry_score    = recent_list[slot].key.score;
                        r.entry_penalty  = recent_list[slot].key.penalty;
                        r.entry_sequence = recent_list[slot].key.seq_num;
                    end
                end
                default:
                begin
                end
            endcase
            r.top_entries    = top_fill[CNT_W-1:0];
            r.recent_entries = recent_fill[CNT_W-1:0];
            replies_due.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("mismatch on %s: expected %0h, got %0h", name, want, got);
                end
            end
        endfunction

        // Compare one transferred result against the oldest queued reply.
        function void check_result(store_reply_t got);
            store_reply_t want;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("result transfer with no reply outstanding");
                end
                return;
            end
            want = replies_due.pop_front();
            check_field("ok", want.ok, got.ok);
            check_field("ranked", want.ranked, got.ranked);
            check_field("rank_position", want.rank_position, got.rank_position);
            check_field("top_entries", want.top_entries, got.top_entries);
            check_field("recent_entries", want.recent_entries, got.recent_entries);
            check_field("entry_status", want.entry_status, got.entry_status);
            check_field("entry_score", want.entry_score, got.entry_score);
            check_field("entry_penalty", want.entry_penalty, got.entry_penalty);
            check_field("entry_sequence", want.entry_sequence, got.entry_sequence);
        endfunction
    endclass

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                item_valid     = 1'b0;
    logic                item_ready;
    logic [1:0]          kind           = '0;
    logic [STATUS_W-1:0] status         = '0;
    logic [DATA_W-1:0]   score_time     = '0;
    logic [DATA_W-1:0]   penalty_time   = '0;
    logic [IDX_W-1:0]    slot_index     = '0;
    logic                result_valid;
    logic                result_ready   = 1'b0;
    logic                ok;
    logic                ranked;
    logic [IDX_W-1:0]    rank_position;
    logic [CNT_W-1:0]    top_entries;
    logic [CNT_W-1:0]    recent_entries;
    logic [STATUS_W-1:0] entry_status;
    logic [DATA_W-1:0]   entry_score;
    logic [DATA_W-1:0]   entry_penalty;
    logic [DATA_W-1:0]   entry_sequence;

    rank_store_scoreboard sb;
    bit                   calm       = 1'b0;
    int unsigned          stall_left = 0;
    int unsigned          cycle_count = 0;

    ranked_top_k_result_store u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .kind           (kind),
        .status         (status),
        .score_time     (score_time),
        .penalty_time   (penalty_time),
        .slot_index     (slot_index),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .ok             (ok),
        .ranked         (ranked),
        .rank_position  (rank_position),
        .top_entries    (top_entries),
        .recent_entries (recent_entries),
        .entry_status   (entry_status),
        .entry_score    (entry_score),
        .entry_penalty  (entry_penalty),
        .entry_sequence (entry_sequence)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure, none while calm, and long hold-offs on request.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (stall_left != 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else if (calm)
            begin
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= 14);
            end
            @(posedge clk);
        end
    end

    // Every result transfer is checked against the predicted reply.
    always @(posedge clk)
    begin : result_monitor
        store_reply_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got.ok             = ok;
            got.ranked         = ranked;
            got.rank_position  = rank_position;
            got.top_entries    = top_entries;
            got.recent_entries = recent_entries;
            got.entry_status   = entry_status;
            got.entry_score    = entry_score;
            got.entry_penalty  = entry_penalty;
            got.entry_sequence = entry_sequence;
            sb.check_result(got);
        end
    end

    // Watchdog on total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offer one request, with an occasional idle gap first, and hold it until the transfer.
    task automatic send_item(kind_t k, logic [STATUS_W-1:0] st, logic [DATA_W-1:0] sc,
                             logic [DATA_W-1:0] pe, logic [IDX_W-1:0] slot);
        int unsigned gap;
        gap = (!calm && $urandom_range(99) < 14) ? $urandom_range(4, 1) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= k;
        status       <= st;
        score_time   <= sc;
        penalty_time <= pe;
        slot_index   <= slot;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(k, st, sc, pe, slot);
    endtask

    // Stop offering and wait until every reply has come back.
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    // Times are often drawn from a small pool so that ties in the ranking keys occur.
    function automatic logic [DATA_W-1:0] pick_time(int unsigned pool);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            return $urandom_range(pool);
        end
        if (sel < 50)
        begin
            return sel[0] ? 32'hFFFF_FFFF : 32'h0;
        end
        return $urandom();
    endfunction

    task automatic send_random_item();
        int unsigned         roll;
        kind_t               k;
        logic [STATUS_W-1:0] st;
        roll = $urandom_range(99);
        if (roll < 52)
        begin
            k = KIND_RECORD;
        end
        else if (roll < 72)
        begin
            k = KIND_READ_TOP;
        end
        else if (roll < 92)
        begin
            k = KIND_READ_RECENT;
        end
        else
        begin
            k = KIND_NOP;
        end
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            st = STATUS_NONE;
        end
        else if (roll < 60)
        begin
            st = STATUS_FINISHED;
        end
        else if (roll < 85)
        begin
            st = STATUS_UNFINISHED;
        end
        else
        begin
            st = STATUS_SPARE;
        end
        send_item(k, st, pick_time(7), pick_time(3), IDX_W'($urandom_range(7)));
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads and a no-op on empty lists, then a refused record.
        send_item(KIND_READ_TOP, STATUS_NONE, 32'h0, 32'h0, 3'd0);
        send_item(KIND_READ_RECENT, STATUS_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        send_item(KIND_NOP, STATUS_FINISHED, 32'h1234_5678, 32'h9ABC_DEF0, 3'd3);
        send_item(KIND_RECORD, STATUS_NONE, 32'h5, 32'h5, 3'd0);

        // Extremes of the keys and a full tie broken by sequence.
        send_item(KIND_RECORD, STATUS_FINISHED, 32'h0, 32'h0, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'h0, 32'hFFFF_FFFF, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'd100, 32'd5, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'd100, 32'd5, 3'd0);

        // Unfinished results and the spare status code land only in the recent list.
        send_item(KIND_RECORD, STATUS_UNFINISHED, 32'd3, 32'd9, 3'd0);
        send_item(KIND_RECORD, STATUS_SPARE, 32'hFFFF_FFFF, 32'h0, 3'd0);

        // Fill the top list so that its worst entry falls off.
        send_item(KIND_RECORD, STATUS_FINISHED, 32'd100, 32'd4, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'd50, 32'd7, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'd7, 32'd7, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'd200, 32'd0, 3'd0);

        // A result ranking after a full list is left out; a tie at the front goes second.
        send_item(KIND_RECORD, STATUS_FINISHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
        send_item(KIND_RECORD, STATUS_FINISHED, 32'h0, 32'h0, 3'd0);

        // Reads at both ends of both full lists.
        send_item(KIND_READ_TOP, STATUS_NONE, 32'h0, 32'h0, 3'd0);
        send_item(KIND_READ_TOP, STATUS_NONE, 32'h0, 32'h0, 3'd1);
        send_item(KIND_READ_TOP, STATUS_NONE, 32'h0, 32'h0, 3'd7);
        send_item(KIND_READ_RECENT, STATUS_NONE, 32'h0, 32'h0, 3'd0);
        send_item(KIND_READ_RECENT, STATUS_NONE, 32'h0, 32'h0, 3'd7);
        send_item(KIND_NOP, STATUS_NONE, 32'h0, 32'h0, 3'd5);

        repeat (300) send_random_item();

        // Hold off the result side while requests keep coming, then let it all drain.
        stall_left = HOLDOFF_LEN;
        calm = 1'b1;
        repeat (30) send_random_item();
        calm = 1'b0;
        wait_drained();

        // A stretch with no idling on either side, then random idling again.
        calm = 1'b1;
        repeat (200) send_random_item();
        calm = 1'b0;
        repeat (370) send_random_item();

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
